FILE: rtl/assert_macros.svh
// Assertion macros for the checker file fud_checker.sv.
// Every macro samples on the rising edge of aclk in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while aresetn is low.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while aresetn is low.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/fud_pkg.sv
// Package for the form-urlencoded pair decoder: codes, types and the hex digit
// decode. Used by every module of the decoder; depends on nothing.
package fud_pkg;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_END  = 1'b1;

    localparam logic [1:0] ST_CONT = 2'd0;
    localparam logic [1:0] ST_PAIR = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    localparam logic [1:0] ESC_IDLE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] LIMIT_RESET = 8'd31;

    // Register indexes on the configuration port.
    localparam logic       REG_NAME_LIMIT  = 1'b0;
    localparam logic       REG_VALUE_LIMIT = 1'b1;
    localparam int         PADDR_W         = 3;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       to_value;
        logic [7:0] char_pos;
        logic [1:0] status;
    } fud_result_t;

    typedef struct packed {
        logic [7:0] name_limit;
        logic [7:0] value_limit;
    } fud_limits_t;

    // Bit 4 is set when the byte is a hex digit; bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

FILE: rtl/fud_cfg_regs.sv
// Configuration registers of the form-urlencoded pair decoder on an APB-style port.
// Depends on fud_pkg.
module fud_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fud_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output fud_pkg::fud_limits_t        limits
);

    logic [7:0] name_limit_reg;
    logic [7:0] value_limit_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_reg  <= fud_pkg::LIMIT_RESET;
            value_limit_reg <= fud_pkg::LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                fud_pkg::REG_NAME_LIMIT:  name_limit_reg  <= pwdata[7:0];
                fud_pkg::REG_VALUE_LIMIT: value_limit_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fud_pkg::REG_NAME_LIMIT:  prdata = {24'd0, name_limit_reg};
            fud_pkg::REG_VALUE_LIMIT: prdata = {24'd0, value_limit_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign limits.name_limit  = name_limit_reg;
    assign limits.value_limit = value_limit_reg;

endmodule

FILE: rtl/fud_decode.sv
// Pair state and per-byte decode of the form-urlencoded pair decoder.
// Depends on fud_pkg; the state advances by one word whenever adv is high.
module fud_decode (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  opcode,
    input  logic [7:0]            body_byte,
    input  fud_pkg::fud_limits_t  limits,
    output fud_pkg::fud_result_t  result
);

    logic       in_value_reg,   in_value_next;
    logic [1:0] esc_step_reg,   esc_step_next;
    logic [3:0] high_nib_reg,   high_nib_next;
    logic       high_ok_reg,    high_ok_next;
    logic [7:0] name_count_reg, name_count_next;
    logic [7:0] val_count_reg,  val_count_next;
    logic       seen_any_reg,   seen_any_next;

    logic [4:0] digit;
    logic       emit;
    logic [7:0] emit_ch;

    assign digit = fud_pkg::hex_digit(body_byte);

    always_comb begin
        in_value_next   = in_value_reg;
        esc_step_next   = esc_step_reg;
        high_nib_next   = high_nib_reg;
        high_ok_next    = high_ok_reg;
        name_count_next = name_count_reg;
        val_count_next  = val_count_reg;
        seen_any_next   = seen_any_reg;
        emit            = 1'b0;
        emit_ch         = 8'd0;
        result          = '0;
        result.status   = fud_pkg::ST_CONT;

        if (opcode == fud_pkg::OP_END) begin
            if (esc_step_reg == fud_pkg::ESC_FIRST || esc_step_reg == fud_pkg::ESC_SECOND) begin
                result.status = fud_pkg::ST_ERR;
            end else begin
                result.status = seen_any_reg ? fud_pkg::ST_PAIR : fud_pkg::ST_NONE;
            end
            in_value_next   = 1'b0;
            esc_step_next   = fud_pkg::ESC_IDLE;
            high_nib_next   = 4'd0;
            high_ok_next    = 1'b0;
            name_count_next = 8'd0;
            val_count_next  = 8'd0;
            seen_any_next   = 1'b0;
        end else begin
            seen_any_next = 1'b1;
            case (esc_step_reg)
                fud_pkg::ESC_FIRST: begin
                    high_nib_next = digit[4] ? digit[3:0] : 4'd0;
                    high_ok_next  = digit[4];
                    esc_step_next = fud_pkg::ESC_SECOND;
                end
                fud_pkg::ESC_SECOND: begin
                    emit = 1'b1;
                    if (!high_ok_reg) begin
                        emit_ch = 8'd0;
                    end else if (digit[4]) begin
                        emit_ch = {high_nib_reg, digit[3:0]};
                    end else begin
                        emit_ch = {4'd0, high_nib_reg};
                    end
                    esc_step_next = fud_pkg::ESC_IDLE;
                    high_nib_next = 4'd0;
                    high_ok_next  = 1'b0;
                end
                default: begin
                    esc_step_next = fud_pkg::ESC_IDLE;
                    case (body_byte)
                        fud_pkg::CH_PLUS: begin
                            emit    = 1'b1;
                            emit_ch = fud_pkg::CH_SPACE;
                        end
                        fud_pkg::CH_EQ: begin
                            in_value_next = 1'b1;
                        end
                        fud_pkg::CH_AMP: begin
                            result.status   = fud_pkg::ST_PAIR;
                            in_value_next   = 1'b0;
                            high_nib_next   = 4'd0;
                            high_ok_next    = 1'b0;
                            name_count_next = 8'd0;
                            val_count_next  = 8'd0;
                            seen_any_next   = 1'b0;
                        end
                        fud_pkg::CH_PCT: begin
                            esc_step_next = fud_pkg::ESC_FIRST;
                        end
                        default: begin
                            emit    = 1'b1;
                            emit_ch = body_byte;
                        end
                    endcase
                end
            endcase

            // Characters past the limit of their part are dropped silently.
            if (emit) begin
                if (!in_value_reg) begin
                    if (name_count_reg < limits.name_limit) begin
                        result.char_out   = emit_ch;
                        result.char_valid = 1'b1;
                        result.char_pos   = name_count_reg;
                        name_count_next   = name_count_reg + 8'd1;
                    end
                end else begin
                    if (val_count_reg < limits.value_limit) begin
                        result.char_out   = emit_ch;
                        result.char_valid = 1'b1;
                        result.to_value   = 1'b1;
                        result.char_pos   = val_count_reg;
                        val_count_next    = val_count_reg + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_value_reg   <= 1'b0;
            esc_step_reg   <= fud_pkg::ESC_IDLE;
            high_nib_reg   <= 4'd0;
            high_ok_reg    <= 1'b0;
            name_count_reg <= 8'd0;
            val_count_reg  <= 8'd0;
            seen_any_reg   <= 1'b0;
        end else if (adv) begin
            in_value_reg   <= in_value_next;
            esc_step_reg   <= esc_step_next;
            high_nib_reg   <= high_nib_next;
            high_ok_reg    <= high_ok_next;
            name_count_reg <= name_count_next;
            val_count_reg  <= val_count_next;
            seen_any_reg   <= seen_any_next;
        end
    end

endmodule

FILE: rtl/form_urlencoded_pair_decoder.sv
// Top level of the form-urlencoded pair decoder: input word register, decode
// stage and result register. Depends on fud_pkg, fud_cfg_regs and fud_decode.
//
//   channel   ports            carries
//   s_        opcode, byte     one body byte or an end-of-body mark per word
//   m_        char, status     one decoded result per input word
//   apb       psel..prdata     name_limit at 0x0, value_limit at 0x4
//
// One word per cycle sustained while results are taken. An accepted word is held
// in the input word register and decoded into the result register once that
// register is free; the result register then offers it on the m_ channel.
// A result that is not taken holds the result register and a full input
// register, and s_ready then drops; an empty input register still takes a word.
// Reset is synchronous and active low; limits reset to 31.
module form_urlencoded_pair_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [7:0]                  s_body_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_char_out,
    output logic                        m_char_valid,
    output logic                        m_to_value,
    output logic [7:0]                  m_char_pos,
    output logic [1:0]                  m_status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fud_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    fud_pkg::fud_limits_t limits;
    fud_pkg::fud_result_t dec_result;
    fud_pkg::fud_result_t result_reg;

    logic       in_valid_reg;
    logic       in_opcode_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       adv;

    assign out_free = !out_valid_reg || m_ready;
    assign adv      = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    fud_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    fud_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .opcode    (in_opcode_reg),
        .body_byte (in_byte_reg),
        .limits    (limits),
        .result    (dec_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= s_opcode;
            in_byte_reg   <= s_body_byte;
        end
        if (adv) begin
            result_reg <= dec_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_char_out   = result_reg.char_out;
    assign m_char_valid = result_reg.char_valid;
    assign m_to_value   = result_reg.to_value;
    assign m_char_pos   = result_reg.char_pos;
    assign m_status     = result_reg.status;

endmodule

FILE: rtl/fud_checker.sv
// Port-level checks for the form-urlencoded pair decoder, bound to its top level.
// Depends on fud_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fud_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char_out,
    input logic       m_char_valid,
    input logic       m_to_value,
    input logic [7:0] m_char_pos,
    input logic [1:0] m_status
);

    // A stalled result word keeps its contents.
    `ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_char_out) && $stable(m_status) && $stable(m_char_pos))

    // A dropped or absent character leaves the character fields cleared.
    `ASSERT_IMP(a_empty_char, m_valid && !m_char_valid, m_char_out == 8'd0 && m_char_pos == 8'd0 && !m_to_value)

    // Characters only come out while a pair is still running.
    `ASSERT_IMP(a_char_cont, m_valid && m_char_valid, m_status == fud_pkg::ST_CONT)

    // Reset empties the result register.
    `ASSERT_NXT_ALWAYS(a_reset_empty, !aresetn, !m_valid)

endmodule

bind form_urlencoded_pair_decoder fud_checker u_fud_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_char_out   (m_char_out),
    .m_char_valid (m_char_valid),
    .m_to_value   (m_to_value),
    .m_char_pos   (m_char_pos),
    .m_status     (m_status)
);
